// File: rtl/ipsp_pkg.sv
`default_nettype none
package ipsp_pkg;

  localparam int unsigned POS_W    = 24;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned EXT_W    = 25;
  localparam int unsigned FBC_W    = 3;

  // last header byte index, record and run-body room checks
  localparam logic [POS_W-1:0] HDR_LAST_POS = 24'd4;
  localparam logic [EXT_W-1:0] REC_ROOM     = 25'd8;
  localparam logic [EXT_W-1:0] RUN_ROOM     = 25'd6;
  localparam logic [POS_W-1:0] POS_MAX      = 24'hFF_FFFF;

  localparam int unsigned OUT_DEPTH_DEF = 4;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_FILL  = 2'd1,
    KIND_END   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_RECORD  = 2'd1,
    PH_RUN     = 2'd2,
    PH_PAYLOAD = 2'd3
  } phase_t;

  typedef struct packed {
    kind_t              kind;
    logic [POS_W-1:0]   address;
    logic [LEN_W-1:0]   count;
    logic [BYTE_W-1:0]  value;
    logic [EXT_W-1:0]   extent;
    logic               has_hunks;
    logic               last;
  } res_t;

  typedef struct packed {
    logic wr0;
    logic wr1;
    res_t r0;
    res_t r1;
  } push_t;

endpackage
`default_nettype wire

// File: rtl/ipsp_parse.sv
`default_nettype none
module ipsp_parse
  import ipsp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              fire,
  input  wire logic [BYTE_W-1:0] patch_byte,
  input  wire logic              first,
  input  wire logic              cfg_we,
  input  wire logic [POS_W-1:0]  cfg_wdata,
  output push_t                  push
);

  logic [POS_W-1:0]  plen_r;
  logic [POS_W-1:0]  pos_r, pos_nxt, cur_pos;
  phase_t            phase_r, phase_nxt, cur_phase;
  logic [FBC_W-1:0]  fbc_r, fbc_nxt, cur_fbc;
  logic [POS_W-1:0]  hoff_r, hoff_nxt, cur_hoff;
  logic [LEN_W-1:0]  hlen_r, hlen_nxt, cur_hlen;
  logic [LEN_W-1:0]  prem_r, prem_nxt, cur_prem;
  logic [EXT_W-1:0]  ext_r, ext_nxt, cur_ext;
  logic              any_r, any_nxt, cur_any;
  logic              stop_r, stop_nxt, cur_stop;
  logic [EXT_W-1:0]  hunk_end;
  logic              cmd_v, end_v;
  kind_t             cmd_kind;
  logic [POS_W-1:0]  cmd_addr;
  logic [LEN_W-1:0]  cmd_cnt;
  res_t              cmd_res, end_res;

  // a first beat sees the cleared parse state
  assign cur_pos   = first ? '0 : pos_r;
  assign cur_phase = first ? PH_HEADER : phase_r;
  assign cur_fbc   = first ? '0 : fbc_r;
  assign cur_hoff  = first ? '0 : hoff_r;
  assign cur_hlen  = first ? '0 : hlen_r;
  assign cur_prem  = first ? '0 : prem_r;
  assign cur_ext   = first ? '0 : ext_r;
  assign cur_any   = first ? 1'b0 : any_r;
  assign cur_stop  = first ? 1'b0 : stop_r;

  always_comb begin
    pos_nxt   = pos_r;
    phase_nxt = phase_r;
    fbc_nxt   = fbc_r;
    hoff_nxt  = hoff_r;
    hlen_nxt  = hlen_r;
    prem_nxt  = prem_r;
    ext_nxt   = ext_r;
    any_nxt   = any_r;
    stop_nxt  = stop_r;
    hunk_end  = '0;
    cmd_v     = 1'b0;
    cmd_kind  = KIND_WRITE;
    cmd_addr  = '0;
    cmd_cnt   = '0;
    end_v     = 1'b0;
    if (fire) begin
      pos_nxt   = cur_pos;
      phase_nxt = cur_phase;
      fbc_nxt   = cur_fbc;
      hoff_nxt  = cur_hoff;
      hlen_nxt  = cur_hlen;
      prem_nxt  = cur_prem;
      ext_nxt   = cur_ext;
      any_nxt   = cur_any;
      stop_nxt  = cur_stop;
      if (cur_pos < plen_r) begin
        if (cur_pos != POS_MAX) begin
          pos_nxt = cur_pos + 24'd1;
        end
        if (!cur_stop) begin
          case (cur_phase)
            PH_HEADER: begin
              if (cur_pos >= HDR_LAST_POS) begin
                phase_nxt = PH_RECORD;
                fbc_nxt   = '0;
              end
            end
            PH_RECORD: begin
              case (cur_fbc)
                3'd0: begin
                  if ({1'b0, cur_pos} + REC_ROOM > {1'b0, plen_r}) begin
                    stop_nxt = 1'b1;
                  end else begin
                    hoff_nxt = {patch_byte, 16'h0000};
                    fbc_nxt  = 3'd1;
                  end
                end
                3'd1: begin
                  hoff_nxt = {cur_hoff[23:16], patch_byte, cur_hoff[7:0]};
                  fbc_nxt  = 3'd2;
                end
                3'd2: begin
                  hoff_nxt = {cur_hoff[23:8], patch_byte};
                  fbc_nxt  = 3'd3;
                end
                3'd3: begin
                  hlen_nxt = {patch_byte, 8'h00};
                  fbc_nxt  = 3'd4;
                end
                default: begin
                  hlen_nxt = {cur_hlen[15:8], patch_byte};
                  fbc_nxt  = '0;
                  if (hlen_nxt != '0) begin
                    hunk_end = {1'b0, cur_hoff} + {9'b0, hlen_nxt};
                    if (hunk_end > cur_ext) begin
                      ext_nxt = hunk_end;
                    end
                    any_nxt   = 1'b1;
                    prem_nxt  = hlen_nxt;
                    phase_nxt = PH_PAYLOAD;
                  end else begin
                    phase_nxt = PH_RUN;
                  end
                end
              endcase
            end
            PH_RUN: begin
              case (cur_fbc)
                3'd0: begin
                  if ({1'b0, cur_pos} + RUN_ROOM > {1'b0, plen_r}) begin
                    stop_nxt = 1'b1;
                  end else begin
                    hlen_nxt = {patch_byte, 8'h00};
                    fbc_nxt  = 3'd1;
                  end
                end
                3'd1: begin
                  hlen_nxt = {cur_hlen[15:8], patch_byte};
                  fbc_nxt  = 3'd2;
                end
                default: begin
                  hunk_end = {1'b0, cur_hoff} + {9'b0, cur_hlen};
                  if (hunk_end > cur_ext) begin
                    ext_nxt = hunk_end;
                  end
                  any_nxt   = 1'b1;
                  cmd_v     = 1'b1;
                  cmd_kind  = KIND_FILL;
                  cmd_addr  = cur_hoff;
                  cmd_cnt   = cur_hlen;
                  fbc_nxt   = '0;
                  phase_nxt = PH_RECORD;
                end
              endcase
            end
            PH_PAYLOAD: begin
              cmd_v    = 1'b1;
              cmd_kind = KIND_WRITE;
              cmd_addr = cur_hoff + {8'h00, cur_hlen - cur_prem};
              cmd_cnt  = 16'd1;
              prem_nxt = cur_prem - 16'd1;
              if (prem_nxt == '0) begin
                phase_nxt = PH_RECORD;
                fbc_nxt   = '0;
              end
            end
            default: begin
              stop_nxt = 1'b1;
            end
          endcase
        end
        end_v = (cur_pos == plen_r - 24'd1);
      end
    end
  end

  always_comb begin
    cmd_res.kind      = cmd_kind;
    cmd_res.address   = cmd_addr;
    cmd_res.count     = cmd_cnt;
    cmd_res.value     = patch_byte;
    cmd_res.extent    = ext_nxt;
    cmd_res.has_hunks = any_nxt;
    cmd_res.last      = !end_v;
    end_res.kind      = KIND_END;
    end_res.address   = '0;
    end_res.count     = '0;
    end_res.value     = '0;
    end_res.extent    = ext_nxt;
    end_res.has_hunks = any_nxt;
    end_res.last      = 1'b1;
    // command goes first when a beat makes both
    push.wr0 = cmd_v || end_v;
    push.wr1 = cmd_v && end_v;
    push.r0  = cmd_v ? cmd_res : end_res;
    push.r1  = end_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plen_r  <= '0;
      pos_r   <= '0;
      phase_r <= PH_HEADER;
      fbc_r   <= '0;
      hoff_r  <= '0;
      hlen_r  <= '0;
      prem_r  <= '0;
      ext_r   <= '0;
      any_r   <= 1'b0;
      stop_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        plen_r <= cfg_wdata;
      end
      pos_r   <= pos_nxt;
      phase_r <= phase_nxt;
      fbc_r   <= fbc_nxt;
      hoff_r  <= hoff_nxt;
      hlen_r  <= hlen_nxt;
      prem_r  <= prem_nxt;
      ext_r   <= ext_nxt;
      any_r   <= any_nxt;
      stop_r  <= stop_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/ipsp_out_fifo.sv
`default_nettype none
module ipsp_out_fifo
  import ipsp_pkg::*;
#(
  parameter int unsigned DEPTH = OUT_DEPTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire push_t push,
  output logic       room2,
  output logic       out_valid,
  input  wire logic  out_ready,
  output res_t       out_res
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  res_t            mem [DEPTH];
  logic [PW-1:0]   wp_r, wp_nxt, wp_inc, rp_r, rp_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            pop;

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    wrap_inc = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt_r != '0);
  assign out_res   = mem[rp_r];
  assign room2     = (cnt_r <= CW'(DEPTH - 2));
  assign wp_inc    = wrap_inc(wp_r);

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    if (push.wr1) begin
      wp_nxt = wrap_inc(wp_inc);
    end else if (push.wr0) begin
      wp_nxt = wp_inc;
    end
    if (pop) begin
      rp_nxt = wrap_inc(rp_r);
    end
    cnt_nxt = cnt_r + CW'(push.wr0) + CW'(push.wr1) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.wr0) begin
      mem[wp_r] <= push.r0;
    end
    if (push.wr1) begin
      mem[wp_inc] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/ips_patch_stream_parser.sv
// a result is registered in the result queue before it reaches the out_ ports
// throughput: one patch byte per cycle while in_ready is high; a byte that makes a
// write or fill and the end result pushes two results, absorbed by the OUT_DEPTH-entry result queue
// in_ready is high while the queue has room for two results
// reset: synchronous active-low rst_n clears patch_length, parse state and queue
`default_nettype none
module ips_patch_stream_parser
  import ipsp_pkg::*;
#(
  parameter int unsigned OUT_DEPTH = OUT_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [BYTE_W-1:0] in_patch_byte,
  input  wire logic              in_first,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [1:0]             out_kind,
  output logic [POS_W-1:0]       out_address,
  output logic [LEN_W-1:0]       out_count,
  output logic [BYTE_W-1:0]      out_value,
  output logic [EXT_W-1:0]       out_extent,
  output logic                   out_has_hunks,
  output logic                   out_last,
  input  wire logic              cfg_we,
  input  wire logic [POS_W-1:0]  cfg_wdata
);

  push_t push;
  res_t  res;
  logic  room2;

  assign in_ready = room2;

  ipsp_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (in_valid && in_ready),
    .patch_byte (in_patch_byte),
    .first      (in_first),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .push       (push)
  );

  ipsp_out_fifo #(
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room2     (room2),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res)
  );

  assign out_kind      = res.kind;
  assign out_address   = res.address;
  assign out_count     = res.count;
  assign out_value     = res.value;
  assign out_extent    = res.extent;
  assign out_has_hunks = res.has_hunks;
  assign out_last      = res.last;

endmodule
`default_nettype wire

// File: rtl/ipsp_checker.sv
`default_nettype none
module ipsp_checker
  import ipsp_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [1:0]        out_kind,
  input wire logic [POS_W-1:0]  out_address,
  input wire logic [LEN_W-1:0]  out_count,
  input wire logic [BYTE_W-1:0] out_value,
  input wire logic [EXT_W-1:0]  out_extent,
  input wire logic              out_has_hunks,
  input wire logic              out_last
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
      $stable(out_address) && $stable(out_count) && $stable(out_value) &&
      $stable(out_extent) && $stable(out_last))
    else $error("result beat changed while stalled");

  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_END |->
      out_last && out_address == '0 && out_count == '0 && out_value == '0)
    else $error("bad end result");

  a_write_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_WRITE |-> out_count == 16'd1 && out_has_hunks)
    else $error("write result with bad count or no hunk");

  // extent only grows from zero once a hunk is seen
  a_no_hunk_extent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_hunks |-> out_extent == '0)
    else $error("extent set without a hunk");

endmodule

bind ips_patch_stream_parser ipsp_checker u_ipsp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_kind      (out_kind),
  .out_address   (out_address),
  .out_count     (out_count),
  .out_value     (out_value),
  .out_extent    (out_extent),
  .out_has_hunks (out_has_hunks),
  .out_last      (out_last)
);
`default_nettype wire

// File: tb/tb_ips_patch_stream_parser.sv
`timescale 1ns / 100ps
module tb_ips_patch_stream_parser;
  import ipsp_pkg::*;

  localparam int STALL_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;

  // literal hunk at the top of the address space running past the end, then one stray beat
  localparam logic [111:0] LIT_PATCH = 112'h5041544348_FFFFFFFFFF_00807F_A5;
  // zero-count fill, then a record that no longer fits
  localparam logic [127:0] RUN_PATCH = 128'h5041544348_0000000000_0000FF_454F46;

  typedef struct packed {
    logic [7:0] data;
    logic       restart;
  } beat_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [7:0]        in_patch_byte = '0;
  logic              in_first = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [1:0]        out_kind;
  logic [POS_W-1:0]  out_address;
  logic [LEN_W-1:0]  out_count;
  logic [BYTE_W-1:0] out_value;
  logic [EXT_W-1:0]  out_extent;
  logic              out_has_hunks;
  logic              out_last;
  logic              cfg_we = 1'b0;
  logic [POS_W-1:0]  cfg_wdata = '0;

  ips_patch_stream_parser dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_patch_byte (in_patch_byte),
    .in_first      (in_first),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_kind      (out_kind),
    .out_address   (out_address),
    .out_count     (out_count),
    .out_value     (out_value),
    .out_extent    (out_extent),
    .out_has_hunks (out_has_hunks),
    .out_last      (out_last),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  beat_t patch_q [$];
  res_t  cmd_q [$];

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  bit hold_req = 1'b0;
  bit in_taken = 1'b0;
  int quiet_cycles = 0;
  int err_cnt = 0;

  // parser state as seen from the testbench
  logic [23:0] plen_m = '0;
  logic [23:0] pos_m = '0;
  phase_t      ph_m = PH_HEADER;
  logic [2:0]  fbc_m = '0;
  logic [23:0] hoff_m = '0;
  logic [15:0] hlen_m = '0;
  logic [15:0] prem_m = '0;
  logic [24:0] mext_m = '0;
  logic        anyh_m = 1'b0;
  logic        stop_m = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void note_hunk();
    if ({1'b0, hoff_m} + {9'h0, hlen_m} > mext_m) begin
      mext_m = {1'b0, hoff_m} + {9'h0, hlen_m};
    end
    anyh_m = 1'b1;
  endfunction

  function automatic res_t command(kind_t k, logic [23:0] a, logic [15:0] c, logic [7:0] v);
    res_t r;
    r.kind = k;
    r.address = a;
    r.count = c;
    r.value = v;
    r.extent = mext_m;
    r.has_hunks = anyh_m;
    r.last = 1'b0;
    return r;
  endfunction

  task automatic parse_byte(input logic [7:0] b, input logic restart);
    logic [23:0] p;
    res_t        made [$];
    if (restart) begin
      pos_m = '0;
      ph_m = PH_HEADER;
      fbc_m = '0;
      hoff_m = '0;
      hlen_m = '0;
      prem_m = '0;
      mext_m = '0;
      anyh_m = 1'b0;
      stop_m = 1'b0;
    end
    p = pos_m;
    if (p >= plen_m) return;
    if (p != 24'hFF_FFFF) pos_m = p + 24'd1;
    if (!stop_m) begin
      case (ph_m)
        PH_HEADER: begin
          if (p >= 24'd4) begin
            ph_m = PH_RECORD;
            fbc_m = '0;
          end
        end
        PH_RECORD: begin
          case (fbc_m)
            3'd0: begin
              if ({1'b0, p} + 25'd8 > {1'b0, plen_m}) begin
                stop_m = 1'b1;
              end else begin
                hoff_m = {b, 16'h0};
                fbc_m = 3'd1;
              end
            end
            3'd1: begin
              hoff_m[15:8] = b;
              fbc_m = 3'd2;
            end
            3'd2: begin
              hoff_m[7:0] = b;
              fbc_m = 3'd3;
            end
            3'd3: begin
              hlen_m = {b, 8'h0};
              fbc_m = 3'd4;
            end
            default: begin
              hlen_m[7:0] = b;
              fbc_m = '0;
              if (hlen_m != 16'h0) begin
                note_hunk();
                prem_m = hlen_m;
                ph_m = PH_PAYLOAD;
              end else begin
                ph_m = PH_RUN;
              end
            end
          endcase
        end
        PH_RUN: begin
          if (fbc_m == 3'd0) begin
            if ({1'b0, p} + 25'd6 > {1'b0, plen_m}) begin
              stop_m = 1'b1;
            end else begin
              hlen_m = {b, 8'h0};
              fbc_m = 3'd1;
            end
          end else if (fbc_m == 3'd1) begin
            hlen_m[7:0] = b;
            fbc_m = 3'd2;
          end else begin
            note_hunk();
            made = {made, command(KIND_FILL, hoff_m, hlen_m, b)};
            fbc_m = '0;
            ph_m = PH_RECORD;
          end
        end
        PH_PAYLOAD: begin
          made = {made, command(KIND_WRITE, hoff_m + {8'h0, hlen_m - prem_m}, 16'd1, b)};
          prem_m = prem_m - 16'd1;
          if (prem_m == 16'h0) begin
            ph_m = PH_RECORD;
            fbc_m = '0;
          end
        end
        default: stop_m = 1'b1;
      endcase
    end
    if (p == plen_m - 24'd1) made = {made, command(KIND_END, '0, '0, '0)};
    if (made.size() != 0) made[made.size()-1].last = 1'b1;
    cmd_q = {cmd_q, made};
  endtask

  function automatic void check_field(string name, logic [24:0] want, logic [24:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      err_cnt++;
    end
  endfunction

  // input beats
  always @(negedge clk) begin : drive
    beat_t nb;
    if (!in_valid || in_taken) begin
      if (patch_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nb = patch_q.pop_front();
        in_valid <= 1'b1;
        in_patch_byte <= nb.data;
        in_first <= nb.restart;
      end else begin
        in_valid <= 1'b0;
      end
    end
    in_taken = 1'b0;
  end

  // result ready, with an optional long hold-off
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin : watch
    res_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        parse_byte(in_patch_byte, in_first);
        in_taken = 1'b1;
      end
      if (out_valid && out_ready) begin
        if (cmd_q.size() == 0) begin
          $error("unexpected result beat: kind %0d address 0x%0h", out_kind, out_address);
          err_cnt++;
        end else begin
          want = cmd_q.pop_front();
          check_field("kind", want.kind, out_kind);
          check_field("address", want.address, out_address);
          check_field("count", want.count, out_count);
          check_field("value", want.value, out_value);
          check_field("extent", want.extent, out_extent);
          check_field("has_hunks", want.has_hunks, out_has_hunks);
          check_field("last", want.last, out_last);
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else if (++quiet_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic push_beat(input logic [7:0] data, input logic restart);
    beat_t x;
    x.data = data;
    x.restart = restart;
    patch_q = {patch_q, x};
  endtask

  task automatic push_packed(input logic [255:0] v, input int nbytes);
    for (int i = 0; i < nbytes; i++) push_beat(v[(nbytes-1-i)*8 +: 8], i == 0);
  endtask

  // random header, then offset/length records with random content, cut at span bytes
  task automatic queue_patch(input int unsigned span);
    logic [7:0]  img [$];
    logic [23:0] at;
    logic [15:0] cnt;
    int          left;
    repeat (5) img = {img, 8'($urandom_range(255))};
    while (img.size() < span) begin
      at = 24'($urandom);
      if ($urandom_range(3) == 0) at[23:8] = 16'hFFFF;
      img = {img, at[23:16], at[15:8], at[7:0]};
      cnt = 16'($urandom);
      if ($urandom_range(99) < 30) begin
        case ($urandom_range(5))
          0: cnt = 16'h0;
          1: cnt = 16'hFFFF;
          default: ;
        endcase
        img = {img, 8'h00, 8'h00, cnt[15:8], cnt[7:0], 8'($urandom_range(255))};
      end else begin
        if ($urandom_range(9) != 0) cnt = 16'(1 + $urandom_range(5));
        img = {img, cnt[15:8], cnt[7:0]};
        left = cnt;
        while (left > 0 && img.size() < span) begin
          img = {img, 8'($urandom_range(255))};
          left--;
        end
      end
    end
    for (int i = 0; i < span; i++) push_beat(img[i], i == 0);
  endtask

  // wait until every beat is taken and every result seen, then let the block go quiet
  task automatic settle();
    while (patch_q.size() != 0 || in_valid || cmd_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_len(input logic [23:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    plen_m = v;
  endtask

  initial begin : stimulus
    logic [23:0] plen;
    int unsigned span;
    int          queued;
    int          budget;
    int          r;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // patch length still zero from reset
    push_beat(8'($urandom_range(255)), 1'b1);
    settle();
    write_len(24'd13);
    push_packed(LIT_PATCH, 14);
    settle();
    write_len(24'd16);
    push_packed(RUN_PATCH, 16);

    for (int ph = 0; ph < 12; ph++) begin
      settle();
      case (ph)
        0: plen = 24'd5;
        1: plen = 24'hFF_FFFF;
        2: plen = 24'd0;
        3: plen = 24'd1;
        default: plen = 24'(8 + $urandom_range(56));
      endcase
      write_len(plen);
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 65; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 65; end
        default: begin send_idle_pct = 6; stall_pct = 6; end
      endcase
      if (ph == 6) begin
        @(posedge clk);
        hold_req = 1'b1;
        @(negedge clk);
      end
      budget = (plen == 24'd0) ? 8 : 24;
      queued = 0;
      while (queued < budget) begin
        r = $urandom_range(9);
        if (plen == 24'hFF_FFFF) span = 40;
        else if (plen == 24'd0) span = 2 + $urandom_range(4);
        else span = plen;
        if (r == 0 && span > 1) span = $urandom_range(span - 1, 1);
        queue_patch(span);
        queued += span;
        // stray beats past the end, or noise that may restart mid-patch
        if (r == 1) begin
          repeat ($urandom_range(3, 1)) push_beat(8'($urandom_range(255)), 1'b0);
        end else if (r == 2) begin
          repeat ($urandom_range(4, 1))
            push_beat(8'($urandom_range(255)), $urandom_range(7) == 0);
        end
      end
    end

    settle();
    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: ips_patch_stream_parser.f
rtl/ipsp_pkg.sv
rtl/ipsp_parse.sv
rtl/ipsp_out_fifo.sv
rtl/ips_patch_stream_parser.sv
rtl/ipsp_checker.sv
tb/tb_ips_patch_stream_parser.sv
